/* sv/pwir_pkg.sv */
// shared types and constants for the pulse-width line transceiver
package pwir_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W = 8;
    localparam int WIDTH_W = 16;
    localparam int TICK_W = 32;
    localparam int STEP_W = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // item kinds
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_EDGE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PUSH = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_WIDTH   = 3'd4;

    // transmit sequence steps
    localparam logic [STEP_W-1:0] STOP_STEP = 5'd18;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd20;

    // window half-widths
    localparam logic [2:0] FRAME_TOL = 3'd5;
    localparam logic [2:0] BIT_TOL   = 3'd2;

    localparam logic [3:0] RX_BITS = 4'd8;

    typedef struct packed {
        logic              line_on;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_data;
        logic              push_accepted;
        logic              tx_busy;
    } out_item_t;

endpackage

/* sv/pwir_in_if.sv */
// input item channel: action and byte to send
interface pwir_in_if;
    import pwir_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   send_data;

    modport source (output valid, output action, output send_data, input ready);
    modport sink (input valid, input action, input send_data, output ready);
endinterface

/* sv/pwir_out_if.sv */
// result item channel: line level, received byte and status
interface pwir_out_if;
    import pwir_pkg::*;

    logic              valid;
    logic              ready;
    logic              line_on;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_data;
    logic              push_accepted;
    logic              tx_busy;

    modport source (output valid, output line_on, output rx_valid, output rx_data,
                    output push_accepted, output tx_busy, input ready);
    modport sink (input valid, input line_on, input rx_valid, input rx_data,
                  input push_accepted, input tx_busy, output ready);
endinterface

/* sv/pwir_cfg_if.sv */
// register write channel: register index and write data
interface pwir_cfg_if;
    import pwir_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/pwir_ram.sv */
// generic single-port-write ram with registered read
module pwir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* sv/pulse_width_ir_transceiver.sv */
// top level of the pulse-width line transceiver
//
// usage
//   req carries one item per transfer: a tick, a receive pin edge or a byte
//   to push into the transmit fifo (action plus send_data)
//   rsp returns exactly one result per req transfer, in order: transmit line
//   level, received byte with its valid flag, push acceptance and busy flag
//   cfg writes the five width registers (start, stop, one, zero, gap) by
//   index; it is always ready and is meant to be written while idle
// timing
//   the rsp item is shown in the cycle after its req transfer;
//   one item per cycle is sustained while rsp is taken, set by the single
//   result register stage that follows the combinational state update
// stalls
//   while rsp is held (valid without ready) the result register is full and
//   req.ready drops; it rises again in the cycle rsp is taken, so a new req
//   transfer can land in the same cycle the old result leaves
// reset
//   rst_n clears all control state, empties the fifo and loads the default
//   widths; the fifo storage itself is not cleared and needs no sweep
module pulse_width_ir_transceiver #(
    parameter int QUEUE_DEPTH = 8
) (
    input logic      clk,
    input logic      rst_n,
    pwir_in_if.sink  req,
    pwir_out_if.source rsp,
    pwir_cfg_if.sink cfg
);
    import pwir_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(2 * QUEUE_DEPTH) + 1;

    // width registers
    logic [WIDTH_W-1:0] start_width_reg, stop_width_reg, one_width_reg;
    logic [WIDTH_W-1:0] zero_width_reg, gap_width_reg;

    // transmit state
    logic [TICK_W-1:0]  tick_count_reg, tick_count_next;
    logic [STEP_W-1:0]  tx_step_reg, tx_step_next;
    logic               tx_active_reg, tx_active_next;
    logic [TICK_W-1:0]  tx_mark_start_reg, tx_mark_start_next;
    logic [WIDTH_W-1:0] tx_mark_len_reg, tx_mark_len_next;
    logic [BYTE_W-1:0]  tx_shift_byte_reg, tx_shift_byte_next;
    logic [CW-1:0]      q_count_reg, q_count_next;
    logic [AW-1:0]      q_head_reg, q_head_next;
    logic               line_level_reg, line_level_next;

    // receive state
    logic [TICK_W-1:0]  rx_edge_time_reg, rx_edge_time_next;
    logic               rx_edge_pending_reg, rx_edge_pending_next;
    logic               rx_frame_open_reg, rx_frame_open_next;
    logic [3:0]         rx_bit_count_reg, rx_bit_count_next;
    logic [BYTE_W-1:0]  rx_shift_byte_reg, rx_shift_byte_next;

    // result register
    logic               rsp_valid_reg;
    out_item_t          rsp_item_reg, rsp_item_next;

    // fifo storage and head look-ahead
    logic               q_we;
    logic [AW-1:0]      q_waddr;
    logic [BYTE_W-1:0]  q_rdata;
    logic               byp_valid_reg;
    logic [BYTE_W-1:0]  byp_data_reg;
    logic [BYTE_W-1:0]  q_front;

    logic               accept;
    logic               deq;
    logic [SW-1:0]      tail_sum;
    logic [TICK_W-1:0]  elapsed;
    logic [TICK_W-1:0]  rx_width;
    logic [2:0]         bit_idx;
    logic               hit_start, hit_stop, hit_one, hit_zero;

    function automatic logic in_window(
        input logic [TICK_W-1:0]  w,
        input logic [WIDTH_W-1:0] centre,
        input logic [2:0]         tol
    );
        logic signed [TICK_W+1:0] v;
        logic signed [TICK_W+1:0] lo;
        logic signed [TICK_W+1:0] hi;
        v  = signed'({2'b00, w});
        lo = signed'({18'd0, centre}) - signed'({31'd0, tol});
        hi = signed'({18'd0, centre}) + signed'({31'd0, tol});
        return (v > lo) && (v < hi);
    endfunction

    assign accept    = req.valid && req.ready;
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    // queue[head] as of the last edge: fresh write wins over the ram read
    assign q_front = byp_valid_reg ? byp_data_reg : q_rdata;

    assign tail_sum = SW'(q_head_reg) + SW'(q_count_reg);
    assign q_waddr  = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                     : AW'(tail_sum);

    // receive width and window hits
    assign rx_width  = tick_count_reg - rx_edge_time_reg;
    assign hit_start = in_window(rx_width, start_width_reg, FRAME_TOL);
    assign hit_stop  = in_window(rx_width, stop_width_reg, FRAME_TOL);
    assign hit_one   = in_window(rx_width, one_width_reg, BIT_TOL);
    assign hit_zero  = in_window(rx_width, zero_width_reg, BIT_TOL);

    always_comb
    begin
        tick_count_next      = tick_count_reg;
        tx_step_next         = tx_step_reg;
        tx_active_next       = tx_active_reg;
        tx_mark_start_next   = tx_mark_start_reg;
        tx_mark_len_next     = tx_mark_len_reg;
        tx_shift_byte_next   = tx_shift_byte_reg;
        q_count_next         = q_count_reg;
        q_head_next          = q_head_reg;
        line_level_next      = line_level_reg;
        rx_edge_time_next    = rx_edge_time_reg;
        rx_edge_pending_next = rx_edge_pending_reg;
        rx_frame_open_next   = rx_frame_open_reg;
        rx_bit_count_next    = rx_bit_count_reg;
        rx_shift_byte_next   = rx_shift_byte_reg;
        rsp_item_next        = '0;
        q_we                 = 1'b0;
        deq                  = 1'b0;
        elapsed              = '0;
        bit_idx              = '0;

        if (accept)
        begin
            case (req.action)
                ACT_TICK:
                begin
                    tick_count_next = tick_count_reg + 32'd1;
                    // idle transmitter pulls the next byte, start mark on this tick
                    if (!tx_active_reg && (q_count_reg != '0))
                    begin
                        deq                = 1'b1;
                        tx_shift_byte_next = q_front;
                        tx_active_next     = 1'b1;
                        tx_step_next       = '0;
                        tx_mark_len_next   = '0;
                    end
                    elapsed = tick_count_next - tx_mark_start_next;
                    if (tx_active_next && (elapsed >= {16'd0, tx_mark_len_next}))
                    begin
                        if (tx_step_next[0])
                        begin
                            // mark done, line off for the gap
                            line_level_next    = 1'b0;
                            tx_mark_start_next = tick_count_next;
                            tx_mark_len_next   = gap_width_reg;
                            tx_step_next       = tx_step_next + 5'd1;
                        end
                        else if (tx_step_next == '0)
                        begin
                            line_level_next    = 1'b1;
                            tx_mark_start_next = tick_count_next;
                            tx_mark_len_next   = start_width_reg;
                            tx_step_next       = tx_step_next + 5'd1;
                        end
                        else if (tx_step_next == STOP_STEP)
                        begin
                            line_level_next    = 1'b1;
                            tx_mark_start_next = tick_count_next;
                            tx_mark_len_next   = stop_width_reg;
                            tx_step_next       = tx_step_next + 5'd1;
                        end
                        else if (tx_step_next >= LAST_STEP)
                        begin
                            // frame end, chain straight into the next byte
                            tx_step_next   = '0;
                            tx_active_next = 1'b0;
                            if (q_count_reg != '0)
                            begin
                                deq                = 1'b1;
                                tx_shift_byte_next = q_front;
                                tx_active_next     = 1'b1;
                                tx_mark_len_next   = '0;
                            end
                        end
                        else
                        begin
                            // data mark, lsb first
                            bit_idx            = 3'(tx_step_next[4:1] - 4'd1);
                            line_level_next    = 1'b1;
                            tx_mark_start_next = tick_count_next;
                            tx_mark_len_next   = tx_shift_byte_next[bit_idx] ? one_width_reg
                                                                             : zero_width_reg;
                            tx_step_next       = tx_step_next + 5'd1;
                        end
                    end
                    if (deq)
                    begin
                        q_count_next = q_count_reg - CW'(1);
                        q_head_next  = (q_head_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                             : q_head_reg + AW'(1);
                    end
                end
                ACT_EDGE:
                begin
                    if (!rx_edge_pending_reg)
                    begin
                        rx_edge_time_next    = tick_count_reg;
                        rx_edge_pending_next = 1'b1;
                    end
                    else
                    begin
                        rx_edge_pending_next = 1'b0;
                        if (hit_start)
                        begin
                            rx_frame_open_next = 1'b1;
                        end
                        if (hit_stop)
                        begin
                            rsp_item_next.rx_valid = 1'b1;
                            rsp_item_next.rx_data  = rx_shift_byte_reg;
                            rx_frame_open_next     = 1'b0;
                            rx_bit_count_next      = '0;
                            rx_shift_byte_next     = '0;
                        end
                        if (hit_one && rx_frame_open_next && (rx_bit_count_next < RX_BITS))
                        begin
                            rx_shift_byte_next = rx_shift_byte_next
                                               | (8'd1 << rx_bit_count_next[2:0]);
                            rx_bit_count_next  = rx_bit_count_next + 4'd1;
                        end
                        if (hit_zero && rx_frame_open_next && (rx_bit_count_next < RX_BITS))
                        begin
                            rx_bit_count_next = rx_bit_count_next + 4'd1;
                        end
                    end
                end
                ACT_PUSH:
                begin
                    if (q_count_reg < CW'(QUEUE_DEPTH))
                    begin
                        q_we                        = 1'b1;
                        q_count_next                = q_count_reg + CW'(1);
                        rsp_item_next.push_accepted = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        rsp_item_next.line_on = line_level_next;
        rsp_item_next.tx_busy = tx_active_next;
    end

    pwir_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (req.send_data),
        .raddr (q_head_next),
        .rdata (q_rdata)
    );

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_width_reg     <= 16'd90;
            stop_width_reg      <= 16'd60;
            one_width_reg       <= 16'd40;
            zero_width_reg      <= 16'd20;
            gap_width_reg       <= 16'd20;
            tick_count_reg      <= '0;
            tx_step_reg         <= '0;
            tx_active_reg       <= 1'b0;
            tx_mark_start_reg   <= '0;
            tx_mark_len_reg     <= '0;
            tx_shift_byte_reg   <= '0;
            q_count_reg         <= '0;
            q_head_reg          <= '0;
            line_level_reg      <= 1'b0;
            rx_edge_time_reg    <= '0;
            rx_edge_pending_reg <= 1'b0;
            rx_frame_open_reg   <= 1'b0;
            rx_bit_count_reg    <= '0;
            rx_shift_byte_reg   <= '0;
            rsp_valid_reg       <= 1'b0;
            byp_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_START_WIDTH: start_width_reg <= cfg.data;
                    CFG_STOP_WIDTH:  stop_width_reg  <= cfg.data;
                    CFG_ONE_WIDTH:   one_width_reg   <= cfg.data;
                    CFG_ZERO_WIDTH:  zero_width_reg  <= cfg.data;
                    CFG_GAP_WIDTH:   gap_width_reg   <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            tick_count_reg      <= tick_count_next;
            tx_step_reg         <= tx_step_next;
            tx_active_reg       <= tx_active_next;
            tx_mark_start_reg   <= tx_mark_start_next;
            tx_mark_len_reg     <= tx_mark_len_next;
            tx_shift_byte_reg   <= tx_shift_byte_next;
            q_count_reg         <= q_count_next;
            q_head_reg          <= q_head_next;
            line_level_reg      <= line_level_next;
            rx_edge_time_reg    <= rx_edge_time_next;
            rx_edge_pending_reg <= rx_edge_pending_next;
            rx_frame_open_reg   <= rx_frame_open_next;
            rx_bit_count_reg    <= rx_bit_count_next;
            rx_shift_byte_reg   <= rx_shift_byte_next;
            // a write landing on the entry the ram is reading this edge
            byp_valid_reg       <= q_we && (q_waddr == q_head_next);
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byp_data_reg <= req.send_data;
        if (accept)
        begin
            rsp_item_reg <= rsp_item_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.line_on       = rsp_item_reg.line_on;
    assign rsp.rx_valid      = rsp_item_reg.rx_valid;
    assign rsp.rx_data       = rsp_item_reg.rx_data;
    assign rsp.push_accepted = rsp_item_reg.push_accepted;
    assign rsp.tx_busy       = rsp_item_reg.tx_busy;

    // fifo fill never passes its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count_reg <= CW'(QUEUE_DEPTH))
        else $error("fifo count beyond depth");

    // an idle transmitter sits at step zero, an active one never passes the last step
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!tx_active_reg |-> tx_step_reg == '0) && (tx_step_reg <= LAST_STEP))
        else $error("transmit step out of range");

    // receive bit count saturates at eight
    a_rx_bits: assert property (@(posedge clk) disable iff (!rst_n)
        rx_bit_count_reg <= RX_BITS)
        else $error("receive bit count beyond eight");

    // a transfer into a full fifo leaves the count unchanged and is refused
    a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.action == ACT_PUSH) && (q_count_reg == CW'(QUEUE_DEPTH))
        |=> (q_count_reg == CW'(QUEUE_DEPTH)) && !rsp_item_reg.push_accepted)
        else $error("push taken into a full fifo");
endmodule
